### src/nds_pkg.sv
// Shared constants, types and nibble mask functions for the nibble diffusion scrambler.
package nds_pkg;

  localparam logic [31:0] KEY_RESET  = 32'h6A09_E667;
  localparam int          FIFO_DEPTH = 4;
  localparam int          PTR_W      = $clog2(FIFO_DEPTH);
  localparam int          CNT_W      = $clog2(FIFO_DEPTH + 1);

  // register indexes
  localparam logic        REG_MODE = 1'b0;
  localparam logic        REG_KEY  = 1'b1;

  // mode codes
  localparam logic        MODE_DIFFUSE   = 1'b0;
  localparam logic        MODE_UNDIFFUSE = 1'b1;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } res_t;

  function automatic logic [4:0] sq_shift(input logic [3:0] k);
    logic [7:0] kk;
    kk = {4'd0, k} * {4'd0, k};
    return kk[4:0];
  endfunction

  // F: nibble XOR low bits of key rotated right by k*k mod 32
  function automatic logic [3:0] mask_f(input logic [31:0] key, input logic [3:0] k);
    logic [63:0] dbl;
    dbl = {key, key} >> sq_shift(k);
    return k ^ dbl[3:0];
  endfunction

  // G: same with a left rotate, i.e. a right rotate by 32 - n
  function automatic logic [3:0] mask_g(input logic [31:0] key, input logic [3:0] k);
    logic [4:0]  sh;
    logic [63:0] dbl;
    sh  = 5'd0 - sq_shift(k);
    dbl = {key, key} >> sh;
    return k ^ dbl[3:0];
  endfunction

endpackage

### src/nibble_diffusion_scrambler_top.sv
// Nibble diffusion scrambler / descrambler over a byte stream, with a small result queue.
// Timing: a de-diffused byte is written to the result queue when it is taken; a diffused byte
//   is written when its successor is taken. The last byte of a message is written together with
//   its predecessor's result and follows it out; a single-byte message is written when taken.
// Throughput: one item per cycle; in_tready drops only while the four-entry result queue
//   holds more than two results, so it cannot take the two results of a last byte.
// Reset (rst_n low, synchronous): mode diffuse, key 0x6A09E667, queue and stream state empty.
module nibble_diffusion_scrambler_top (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_wdata,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  input  logic                 in_tlast,   // end_of_message
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] out_byte
  output logic                 out_tlast   // out_last
);
  import nds_pkg::*;

  logic                mode_r;
  logic [31:0]         key_r;
  logic [7:0]          held_byte_r, held_byte_nxt;
  logic                held_valid_r, held_valid_nxt;
  logic [3:0]          prev_hi_r, prev_hi_nxt;
  logic                in_msg_r, in_msg_nxt;

  res_t                fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r;

  logic                in_acc, out_acc;
  logic [3:0]          hi, lo, lo_fix, hi_fix;
  logic [7:0]          cur;
  res_t                res0, res1;
  logic [1:0]          n_push;

  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign in_tready  = count_r <= CNT_W'(FIFO_DEPTH - 2);
  assign out_tvalid = count_r != '0;
  assign out_tdata  = fifo_r[rd_ptr_r].data;
  assign out_tlast  = fifo_r[rd_ptr_r].last;

  assign hi = in_tdata[7:4];
  assign lo = in_tdata[3:0];

  always_comb begin
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    prev_hi_nxt    = prev_hi_r;
    in_msg_nxt     = in_msg_r;
    res0           = '0;
    res1           = '0;
    n_push         = 2'd0;
    lo_fix         = lo;
    hi_fix         = hi;
    cur            = '0;
    if (mode_r == MODE_DIFFUSE) begin
      cur = {hi ^ mask_f(key_r, lo), lo};
      if (held_valid_r) begin
        // held byte gets G of this byte's original high nibble
        res0   = '{last: 1'b0, data: held_byte_r ^ {4'd0, mask_g(key_r, hi)}};
        n_push = 2'd1;
        if (in_tlast) begin
          res1   = '{last: 1'b1, data: cur};
          n_push = 2'd2;
        end
      end else if (in_tlast) begin
        res0   = '{last: 1'b1, data: cur};
        n_push = 2'd1;
      end
      held_byte_nxt  = in_tlast ? 8'd0 : cur;
      held_valid_nxt = !in_tlast;
      in_msg_nxt     = !in_tlast;
    end else begin
      if (in_msg_r) lo_fix = lo ^ mask_g(key_r, prev_hi_r);
      hi_fix      = hi ^ mask_f(key_r, lo_fix);
      res0        = '{last: in_tlast, data: {hi_fix, lo_fix}};
      n_push      = 2'd1;
      prev_hi_nxt = in_tlast ? 4'd0 : hi_fix;
      in_msg_nxt  = !in_tlast;
    end
  end

  // configuration and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_DIFFUSE;
      key_r        <= KEY_RESET;
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      prev_hi_r    <= '0;
      in_msg_r     <= 1'b0;
    end else if (cfg_we && cfg_index == REG_MODE) begin
      // a mode write drops any message in progress
      mode_r       <= cfg_wdata[0];
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      prev_hi_r    <= '0;
      in_msg_r     <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_KEY) key_r <= cfg_wdata;
      if (in_acc) begin
        held_byte_r  <= held_byte_nxt;
        held_valid_r <= held_valid_nxt;
        prev_hi_r    <= prev_hi_nxt;
        in_msg_r     <= in_msg_nxt;
      end
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_acc) wr_ptr_r <= wr_ptr_r + PTR_W'(n_push);
      if (out_acc) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r <= count_r + (in_acc ? CNT_W'(n_push) : CNT_W'(0))
                         - (out_acc ? CNT_W'(1) : CNT_W'(0));
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (in_acc && n_push != 2'd0) fifo_r[wr_ptr_r] <= res0;
    if (in_acc && n_push == 2'd2) fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
  end

endmodule

### src/nds_checker.sv
// Port-level checks for the nibble diffusion scrambler, bound to the top level.
module nds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [31:0] cfg_wdata,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  // results only come from items taken the cycle before
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result appeared without an accepted item");

  // back-pressure only while results are queued
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with an empty result queue");

endmodule

bind nibble_diffusion_scrambler_top nds_checker u_nds_checker (.*);
